@@ src/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

    // Request: one console operation.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_req;

    // Response: cell read back and the cursor after the operation.
    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } t_rsp;

    localparam logic [1:0]  OP_PRINT     = 2'd0;
    localparam logic [1:0]  OP_CLEAR     = 2'd1;
    localparam logic [1:0]  OP_READ      = 2'd2;

    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  ATTR_RESET   = 8'h07;
    localparam logic [15:0] RESET_BLANK  = 16'h0720;

endpackage

@@ src/tcw_frame_ram.sv @@
`timescale 1ns / 1ps

module tcw_frame_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/text_console_writer.sv @@
`timescale 1ns / 1ps

// Text console writer: a ROWS x COLUMNS frame of 16-bit cells (attribute in
// the high byte, character in the low byte) with a cursor.
// Request channel i_valid/o_ready/i_req: print a character (newline moves to
// the start of the next row), clear the screen, or read one cell.
// Response channel o_valid/i_ready/o_rsp: one response per request with the
// cell read (0 for other operations) and the cursor after the operation.
// i_cfg_we/i_cfg_data write the colour attribute byte (reset value 7); write
// it only while the block is idle.
// Order: a print, newline without scroll or unused opcode goes from acceptance
// to S_OUT, an in-range read through S_READ first. Clear screen passes through
// S_CLEAR; a scroll through S_SCROLL and S_BLANK, one cell moved per cycle
// through the single write port of the frame memory, under one address counter.
// One request is worked on at a time; o_ready is high only while idle, so the
// next request is taken only once the last response is handed over.
// After reset a clearing pass fills the frame with blanks (0x0720) with o_ready
// low; configuration writes are still taken.
// The response sits in an output register: a stalled receiver does not block
// acceptance of the next request, but its hand-off waits with o_ready low.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tcw_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output tcw_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] LAST_ROW0 = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_SCROLL = 7'b0001000,
        S_BLANK  = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_base, n_base;         // row * COLUMNS, kept incrementally
    logic [7:0]    r_attr, n_attr;
    logic          r_cp_valid, n_cp_valid; // copy write pending from last read
    logic [AW-1:0] r_cp_addr, n_cp_addr;
    logic [15:0]   r_value, n_value;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;

    logic          accept;
    logic [AW-1:0] cursor_addr;
    logic [15:0]   blank;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    tcw_frame_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign cursor_addr = r_base + AW'(r_col);
    assign blank       = {r_attr, SPACE_CODE};
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_out;

    // Frame memory port steering.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = blank;
        ram_raddr = r_ptr + ROW_STEP;   // source row during a scroll
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = RESET_BLANK;
            end
            S_IDLE: begin
                ram_raddr = AW'(i_req.cell_index);
                if (accept && i_req.opcode == OP_PRINT
                        && i_req.char_code != NEWLINE_CODE) begin
                    ram_we    = 1'b1;
                    ram_waddr = cursor_addr;
                    ram_wdata = {r_attr, i_req.char_code};
                end
            end
            S_SCROLL: begin
                ram_we    = r_cp_valid;
                ram_waddr = r_cp_addr;
                ram_wdata = ram_rdata;
            end
            S_BLANK: begin
                // Finish the last copy before blanking the bottom row.
                ram_we = 1'b1;
                if (r_cp_valid) begin
                    ram_waddr = r_cp_addr;
                    ram_wdata = ram_rdata;
                end
            end
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_attr      = i_cfg_we ? i_cfg_data : r_attr;
        n_cp_valid  = 1'b0;
        n_cp_addr   = r_cp_addr;
        n_value     = r_value;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;

        case (r_state)
            S_INIT: begin
                if (r_ptr == LAST_CELL) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_value = '0;
                    n_state = S_OUT;
                    case (i_req.opcode)
                        OP_PRINT: begin
                            if (i_req.char_code == NEWLINE_CODE || r_col == COL_LAST) begin
                                // Advance to the next row, scroll past the bottom.
                                n_col = '0;
                                if (r_row == ROW_LAST) begin
                                    n_ptr   = '0;
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row  = r_row + 1'b1;
                                    n_base = r_base + ROW_STEP;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_ptr   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_READ: begin
                            if (32'(i_req.cell_index) < 32'(CELLS)) begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_value = ram_rdata;
                n_state = S_OUT;
            end
            S_SCROLL: begin
                // Read one row ahead, write it back on the next cycle.
                n_cp_valid = 1'b1;
                n_cp_addr  = r_ptr;
                if (r_ptr == COPY_LAST) begin
                    n_ptr   = LAST_ROW0;
                    n_state = S_BLANK;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_BLANK: begin
                if (!r_cp_valid) begin
                    if (r_ptr == LAST_CELL) begin
                        n_state = S_OUT;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                if (r_ptr == LAST_CELL) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_base  = '0;
                    n_state = S_OUT;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_OUT: begin
                // Hand the response over once the output register is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_value = r_value;
                    n_out.cursor_row = 5'(r_row);
                    n_out.cursor_col = 7'(r_col);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_ptr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_attr      <= ATTR_RESET;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_attr      <= n_attr;
            r_cp_valid  <= n_cp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        r_value   <= n_value;
        r_out     <= n_out;
    end

endmodule
